// File: sv/line_rasterizer_assert.svh
// Assertion macros for the line rasterizer.
// LR_ASSERT checks a property on every rising edge outside reset.
// LR_ASSERT_ALWAYS checks a property on every rising edge, reset included.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define LR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("line_rasterizer assertion failed");
`define LR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("line_rasterizer assertion failed");
`else
`define LR_ASSERT(label, prop)
`define LR_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: sv/lr_pkg.sv
`default_nettype none

package lr_pkg;

    // Coordinate, delta and decision widths.
    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 4;

    // Opcodes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DEC_BITS-1:0]   t_dec;
    typedef logic [2:0]                   t_octant;

    // Octant codes: major axis, x direction, y direction.
    localparam t_octant OCT_X_PP = 3'd0;
    localparam t_octant OCT_Y_PP = 3'd1;
    localparam t_octant OCT_Y_NP = 3'd2;
    localparam t_octant OCT_X_NP = 3'd3;
    localparam t_octant OCT_X_NN = 3'd4;
    localparam t_octant OCT_Y_NN = 3'd5;
    localparam t_octant OCT_Y_PN = 3'd6;
    localparam t_octant OCT_X_PN = 3'd7;

    typedef struct packed {
        logic   opcode;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
        logic   no_line;
    } t_out_item;

    // Line setup computed from the endpoints of a start item.
    typedef struct packed {
        t_octant octant;
        t_coord  major_end;
        t_dec    decision;
        t_dec    inc_straight;
        t_dec    inc_diagonal;
        logic    last;
    } t_setup;

    // True when the octant steps along y every pixel.
    function automatic logic oct_y_major(t_octant oct);
        logic r;
        unique case (oct)
            OCT_Y_PP, OCT_Y_NP, OCT_Y_NN, OCT_Y_PN: r = 1'b1;
            default:                                r = 1'b0;
        endcase
        return r;
    endfunction

    // True when the octant moves toward smaller x.
    function automatic logic oct_x_neg(t_octant oct);
        logic r;
        unique case (oct)
            OCT_Y_NP, OCT_X_NP, OCT_X_NN, OCT_Y_NN: r = 1'b1;
            default:                                r = 1'b0;
        endcase
        return r;
    endfunction

    // True when the octant moves toward smaller y.
    function automatic logic oct_y_neg(t_octant oct);
        logic r;
        unique case (oct)
            OCT_X_NN, OCT_Y_NN, OCT_Y_PN, OCT_X_PN: r = 1'b1;
            default:                                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/lr_setup.sv
`default_nettype none

module lr_setup (
    input  lr_pkg::t_in_item i_item,
    output lr_pkg::t_setup   o_setup
);
    import lr_pkg::*;

    logic signed [DELTA_BITS-1:0] w_dx;
    logic signed [DELTA_BITS-1:0] w_dy;
    logic [DELTA_BITS-1:0]        w_adx;
    logic [DELTA_BITS-1:0]        w_ady;
    t_octant                      w_oct;
    logic                         w_ymaj;
    logic [COORD_BITS-1:0]        w_a;
    logic [COORD_BITS-1:0]        w_b;
    t_dec                         w_two_a;
    t_dec                         w_two_b;
    t_dec                         w_a_ext;

    // Deltas and their magnitudes.
    assign w_dx  = DELTA_BITS'(i_item.end_x) - DELTA_BITS'(i_item.start_x);
    assign w_dy  = DELTA_BITS'(i_item.end_y) - DELTA_BITS'(i_item.start_y);
    assign w_adx = w_dx[DELTA_BITS-1] ? $unsigned(-w_dx) : $unsigned(w_dx);
    assign w_ady = w_dy[DELTA_BITS-1] ? $unsigned(-w_dy) : $unsigned(w_dy);

    // Zone tests in order; equal magnitudes make y the major axis.
    always_comb begin
        priority if (w_dx == 0 && w_dy == 0) begin
            w_oct = OCT_X_PP;
        end else if (w_dx > 0 && w_dy >= 0) begin
            w_oct = (w_adx > w_ady) ? OCT_X_PP : OCT_Y_PP;
        end else if (w_dx <= 0 && w_dy > 0) begin
            w_oct = (w_adx > w_ady) ? OCT_X_NP : OCT_Y_NP;
        end else if (w_dx < 0 && w_dy <= 0) begin
            w_oct = (w_adx > w_ady) ? OCT_X_NN : OCT_Y_NN;
        end else begin
            w_oct = (w_adx > w_ady) ? OCT_X_PN : OCT_Y_PN;
        end
    end

    // Major and minor magnitudes; both fit in COORD_BITS unsigned.
    assign w_ymaj = oct_y_major(w_oct);
    assign w_a    = w_ymaj ? w_ady[COORD_BITS-1:0] : w_adx[COORD_BITS-1:0];
    assign w_b    = w_ymaj ? w_adx[COORD_BITS-1:0] : w_ady[COORD_BITS-1:0];

    assign w_two_a = {{(DEC_BITS-COORD_BITS-1){1'b0}}, w_a, 1'b0};
    assign w_two_b = {{(DEC_BITS-COORD_BITS-1){1'b0}}, w_b, 1'b0};
    assign w_a_ext = {{(DEC_BITS-COORD_BITS){1'b0}}, w_a};

    // Decision variable and its two increments.
    always_comb begin
        o_setup.octant       = w_oct;
        o_setup.major_end    = w_ymaj ? i_item.end_y : i_item.end_x;
        o_setup.decision     = w_two_b - w_a_ext;
        o_setup.inc_straight = w_two_b;
        o_setup.inc_diagonal = w_two_b - w_two_a;
        o_setup.last         = (w_a == '0);
    end

endmodule

`default_nettype wire

// File: sv/line_rasterizer.sv
`default_nettype none
// Midpoint line rasterizer, all eight octants.
// Input channel (i_in_valid / o_in_ready, i_in_item): a start item carries
// two endpoints and returns the start pixel; a step item returns the next
// pixel along the major axis, with last_pixel set on the end point. A step
// with no line in progress returns no_line with zero coordinates. A start
// abandons any line in progress.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per
// input item, in order.
// An accepted item waits in the input register until the compute stage
// fires, which a full output register that is not being taken holds off;
// its result is then registered in the output register.
// Throughput: one item per cycle unless stalled. The line state is
// updated in the same cycle the result is registered, so back-to-back
// steps chain directly. Reset clears the line state (no line in progress)
// and empties both registers. When the receiver stalls, the result holds
// in the output register, one more item waits in the input register, and
// o_in_ready then drops until the output is taken.

module line_rasterizer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lr_pkg::t_in_item    i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lr_pkg::t_out_item   o_out_item
);
    import lr_pkg::*;

`include "line_rasterizer_assert.svh"

    // Input and output registers.
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in, n_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Line state.
    t_coord  r_cur_x, n_cur_x;
    t_coord  r_cur_y, n_cur_y;
    t_coord  r_major_end, n_major_end;
    t_dec    r_decision, n_decision;
    t_dec    r_inc_straight, n_inc_straight;
    t_dec    r_inc_diagonal, n_inc_diagonal;
    t_octant r_octant, n_octant;
    logic    r_active, n_active;

    logic    w_fire;
    t_setup  w_setup;
    logic    w_ymaj;
    logic    w_diag;
    t_coord  w_step_x;
    t_coord  w_step_y;
    t_coord  w_nx;
    t_coord  w_ny;
    t_dec    w_ndec;
    logic    w_step_last;

    // The compute stage fires when it holds an item and the output can take it.
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    lr_setup u_setup (
        .i_item  (r_in),
        .o_setup (w_setup)
    );

    // One midpoint step from the current state.
    assign w_ymaj   = oct_y_major(r_octant);
    assign w_diag   = !r_decision[DEC_BITS-1];
    assign w_step_x = oct_x_neg(r_octant) ? '1 : COORD_BITS'(1);
    assign w_step_y = oct_y_neg(r_octant) ? '1 : COORD_BITS'(1);
    assign w_nx     = r_cur_x + ((!w_ymaj || w_diag) ? w_step_x : '0);
    assign w_ny     = r_cur_y + ((w_ymaj || w_diag) ? w_step_y : '0);
    assign w_ndec   = r_decision + (w_diag ? r_inc_diagonal : r_inc_straight);
    assign w_step_last = w_ymaj ? (w_ny == r_major_end) : (w_nx == r_major_end);

    // Next values of the registers.
    always_comb begin
        n_in_valid     = r_in_valid;
        n_in           = r_in;
        n_out_valid    = r_out_valid;
        n_out          = r_out;
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_major_end    = r_major_end;
        n_decision     = r_decision;
        n_inc_straight = r_inc_straight;
        n_inc_diagonal = r_inc_diagonal;
        n_octant       = r_octant;
        n_active       = r_active;

        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in       = i_in_item;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_fire) begin
            n_out_valid = 1'b1;
            priority if (r_in.opcode == OP_START) begin
                n_cur_x        = r_in.start_x;
                n_cur_y        = r_in.start_y;
                n_major_end    = w_setup.major_end;
                n_decision     = w_setup.decision;
                n_inc_straight = w_setup.inc_straight;
                n_inc_diagonal = w_setup.inc_diagonal;
                n_octant       = w_setup.octant;
                n_active       = !w_setup.last;
                n_out.pixel_x    = r_in.start_x;
                n_out.pixel_y    = r_in.start_y;
                n_out.last_pixel = w_setup.last;
                n_out.no_line    = 1'b0;
            end else if (r_active) begin
                n_cur_x    = w_nx;
                n_cur_y    = w_ny;
                n_decision = w_ndec;
                n_active   = !w_step_last;
                n_out.pixel_x    = w_nx;
                n_out.pixel_y    = w_ny;
                n_out.last_pixel = w_step_last;
                n_out.no_line    = 1'b0;
            end else begin
                n_out.pixel_x    = '0;
                n_out.pixel_y    = '0;
                n_out.last_pixel = 1'b0;
                n_out.no_line    = 1'b1;
            end
        end
    end

    // Control and line state are cleared by reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_major_end    <= '0;
            r_decision     <= '0;
            r_inc_straight <= '0;
            r_inc_diagonal <= '0;
            r_octant       <= OCT_X_PP;
            r_active       <= 1'b0;
        end else begin
            r_in_valid     <= n_in_valid;
            r_out_valid    <= n_out_valid;
            r_cur_x        <= n_cur_x;
            r_cur_y        <= n_cur_y;
            r_major_end    <= n_major_end;
            r_decision     <= n_decision;
            r_inc_straight <= n_inc_straight;
            r_inc_diagonal <= n_inc_diagonal;
            r_octant       <= n_octant;
            r_active       <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    // A no_line result carries zero coordinates and no last flag.
    `LR_ASSERT(a_no_line_zero, (r_out_valid && r_out.no_line) |->
        (r_out.pixel_x == 0 && r_out.pixel_y == 0 && !r_out.last_pixel))
    // Delivering the last pixel of a line ends it.
    `LR_ASSERT(a_last_ends_line, (w_fire && n_out.last_pixel) |=> !r_active)
    // A step with no line in progress leaves the position untouched.
    `LR_ASSERT(a_idle_step_holds, (w_fire && !r_active && r_in.opcode == OP_STEP) |=>
        ($stable(r_cur_x) && $stable(r_cur_y) && !r_active))
    // A held item in the input register is not overwritten while stalled.
    `LR_ASSERT(a_in_reg_holds, (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in)))
    // Reset leaves both registers empty.
    `LR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_in_valid && !r_out_valid && !r_active))

endmodule

`default_nettype wire
